@@ hw/rtl/rmcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rmcs_pkg: shared types and constants of the redmean nearest color search
// Holds the item payload types, the item kind codes, the controller states
// and the weights of the scaled redmean distance.
// ----------------------------------------------------------------------------
package rmcs_pkg;

    // Default palette depth.
    localparam int DEPTH_DEFAULT = 256;

    // Field widths.
    localparam int CHAN_W = 8;
    localparam int SLOT_W = 8;
    localparam int DIST_W = 29;

    // Distance weights, all scaled by 512.
    localparam logic [10:0] RED_BASE  = 11'd1024;
    localparam logic [10:0] BLUE_BASE = 11'd1534;

    // Item kind codes; the fourth code is unused and ignored.
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    // One color.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // Input item payload.
    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } req_item_t;

    // Result item payload.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] best_slot;
        logic [DIST_W-1:0] best_distance;
    } rsp_item_t;

    // Flags that travel with each entry through the distance pipeline.
    typedef struct packed {
        logic live;  // a read of the palette sits in this stage
        logic hit;   // the entry read was marked valid
    } pipe_flags_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

@@ hw/rtl/rmcs_req_if.sv @@
// ----------------------------------------------------------------------------
// rmcs_req_if: input item channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface rmcs_req_if
    import rmcs_pkg::*;
();
    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/rmcs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rmcs_rsp_if: result item channel
// Valid/ready channel that carries one query result item.
// ----------------------------------------------------------------------------
interface rmcs_rsp_if
    import rmcs_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/redmean_nearest_color_search_core.sv @@
// ----------------------------------------------------------------------------
// redmean_nearest_color_search_core: palette table with nearest color query
// Keeps TABLE_DEPTH palette colors with valid marks in two memories and
// answers a query with the valid slot of least scaled redmean distance.
//
//   Channel  Role  Moves                                 Per item
//   req      sink  write slot, clear all, query color    zero or one result
//   rsp      src   found, best_slot, best_distance       one per query
//
// A write or an unused kind is taken while idle and leaves the controller
// idle. A clear sweeps the valid memory at one entry per cycle, and the same
// sweep runs after reset; no item is taken during a sweep. A query reads one
// entry per cycle from the memory port, then drains the four stage read and
// distance pipeline and loads the result register. The result register holds
// a result while rsp stalls, and new items are taken meanwhile; a later query
// waits only for that register.
// ----------------------------------------------------------------------------
module redmean_nearest_color_search_core
    import rmcs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    rmcs_req_if.sink   req,
    rmcs_rsp_if.source rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    // Palette memories.
    rgb_t color_mem [TABLE_DEPTH];
    logic valid_mem [TABLE_DEPTH];

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;

    // Controller outputs.
    logic              req_ready;
    logic              clear_we;
    logic              scan_issue;
    logic              load_rsp;

    logic              req_fire;
    logic              is_write;
    logic              is_clear;
    logic              is_query;
    logic              slot_in_range;
    logic [31:0]       slot_wide;
    logic [IDX_W-1:0]  slot_idx;
    logic              color_we;
    logic              valid_we;
    logic [IDX_W-1:0]  valid_addr;
    logic              valid_wdata;

    rgb_t              query_reg;
    rgb_t              rd_color_reg;
    logic              rd_valid_reg;
    logic              iss_live_reg;
    logic [IDX_W-1:0]  iss_idx_reg;

    pipe_flags_t       iss_flags;
    pipe_flags_t       dist_flags;
    logic [IDX_W-1:0]  dist_idx;
    logic [DIST_W-1:0] dist_value;
    logic              dist_busy;
    logic              pipe_busy;

    logic              best_found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic              take_best;
    logic [31:0]       best_idx_wide;

    logic              rsp_valid_reg;
    rsp_item_t         rsp_data_reg;
    logic              rsp_free;

    // Item decode.
    always_comb
    begin
        is_write = 1'b0;
        is_clear = 1'b0;
        is_query = 1'b0;
        unique case (req.data.kind)
            KIND_WRITE: is_write = 1'b1;
            KIND_CLEAR: is_clear = 1'b1;
            KIND_QUERY: is_query = 1'b1;
            default:    ;
        endcase
    end

    assign req_fire      = req.valid & req_ready;
    assign slot_wide     = 32'(req.data.slot);
    assign slot_in_range = (slot_wide < 32'(TABLE_DEPTH));
    assign slot_idx      = slot_wide[IDX_W-1:0];
    assign rsp_free      = !rsp_valid_reg || rsp.ready;
    assign pipe_busy     = iss_live_reg | dist_busy;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (idx_reg == IDX_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_fire && is_clear)
                    state_next = ST_CLEAR;
                else if (req_fire && is_query)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg == IDX_LAST)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        req_ready  = 1'b0;
        clear_we   = 1'b0;
        scan_issue = 1'b0;
        load_rsp   = 1'b0;
        idx_next   = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_we = 1'b1;
                idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
            end
            ST_IDLE:   req_ready = 1'b1;
            ST_SCAN:
            begin
                scan_issue = 1'b1;
                idx_next   = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
            end
            ST_DRAIN:  ;
            ST_FINISH: load_rsp = rsp_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Memory write ports: a write item sets a slot, a sweep clears marks.
    assign color_we    = req_fire & is_write & slot_in_range;
    assign valid_we    = color_we | clear_we;
    assign valid_addr  = clear_we ? idx_reg : slot_idx;
    assign valid_wdata = !clear_we;

    always_ff @(posedge clk)
    begin
        if (color_we)
            color_mem[slot_idx] <= rgb_t'({req.data.red, req.data.green, req.data.blue});
    end

    always_ff @(posedge clk)
    begin
        if (valid_we)
            valid_mem[valid_addr] <= valid_wdata;
    end

    // Memory read port, registered, addressed by the scan counter.
    always_ff @(posedge clk)
    begin
        rd_color_reg <= color_mem[idx_reg];
        rd_valid_reg <= valid_mem[idx_reg];
        iss_idx_reg  <= idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iss_live_reg <= 1'b0;
        else
            iss_live_reg <= scan_issue;
    end

    // Query color is held for the whole scan.
    always_ff @(posedge clk)
    begin
        if (req_fire && is_query)
            query_reg <= rgb_t'({req.data.red, req.data.green, req.data.blue});
    end

    assign iss_flags.live = iss_live_reg;
    assign iss_flags.hit  = rd_valid_reg;

    rmcs_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_flags  (iss_flags),
        .in_idx    (iss_idx_reg),
        .entry     (rd_color_reg),
        .query     (query_reg),
        .out_flags (dist_flags),
        .out_idx   (dist_idx),
        .out_dist  (dist_value),
        .busy      (dist_busy)
    );

    // Running best; a strictly smaller distance wins, so ties keep the lower slot.
    assign take_best = dist_flags.live && dist_flags.hit
                    && (!best_found_reg || (dist_value < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            best_found_reg <= 1'b0;
        else if (req_fire && is_query)
            best_found_reg <= 1'b0;
        else if (take_best)
            best_found_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && is_query)
        begin
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
        end
        else if (take_best)
        begin
            best_idx_reg  <= dist_idx;
            best_dist_reg <= dist_value;
        end
    end

    assign best_idx_wide = 32'(best_idx_reg);

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (load_rsp)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_data_reg.found         <= best_found_reg;
            rsp_data_reg.best_slot     <= best_idx_wide[SLOT_W-1:0];
            rsp_data_reg.best_distance <= best_dist_reg;
        end
    end

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

@@ hw/rtl/rmcs_dist.sv @@
// ----------------------------------------------------------------------------
// rmcs_dist: redmean distance pipeline
// Three stages: component squares and weights, weighted products, final sum.
// Takes one palette entry per cycle and never stalls.
// ----------------------------------------------------------------------------
module rmcs_dist
    import rmcs_pkg::*;
#(
    parameter int IDX_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_flags_t       in_flags,
    input  logic [IDX_W-1:0]  in_idx,
    input  rgb_t              entry,
    input  rgb_t              query,
    output pipe_flags_t       out_flags,
    output logic [IDX_W-1:0]  out_idx,
    output logic [DIST_W-1:0] out_dist,
    output logic              busy
);

    logic [CHAN_W-1:0] dr;
    logic [CHAN_W-1:0] dg;
    logic [CHAN_W-1:0] db;
    logic [8:0]        rsum;

    pipe_flags_t       s1_flags_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [15:0]       sq_r_reg;
    logic [15:0]       sq_g_reg;
    logic [15:0]       sq_b_reg;
    logic [10:0]       w_r_reg;
    logic [10:0]       w_b_reg;

    pipe_flags_t       s2_flags_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic [26:0]       term_r_reg;
    logic [26:0]       term_g_reg;
    logic [26:0]       term_b_reg;

    pipe_flags_t       s3_flags_reg;
    logic [IDX_W-1:0]  s3_idx_reg;
    logic [DIST_W-1:0] dist_reg;

    // Absolute component differences and the red sum.
    always_comb
    begin
        dr   = (entry.red > query.red) ? entry.red - query.red : query.red - entry.red;
        dg   = (entry.green > query.green) ? entry.green - query.green
                                           : query.green - entry.green;
        db   = (entry.blue > query.blue) ? entry.blue - query.blue
                                         : query.blue - entry.blue;
        rsum = {1'b0, entry.red} + {1'b0, query.red};
    end

    // Stage flags shift down the pipeline; reset empties it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_flags_reg <= '0;
            s2_flags_reg <= '0;
            s3_flags_reg <= '0;
        end
        else
        begin
            s1_flags_reg <= in_flags;
            s2_flags_reg <= s1_flags_reg;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    // Stage one: squares of the differences and the red and blue weights.
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= in_idx;
        sq_r_reg   <= {8'd0, dr} * {8'd0, dr};
        sq_g_reg   <= {8'd0, dg} * {8'd0, dg};
        sq_b_reg   <= {8'd0, db} * {8'd0, db};
        w_r_reg    <= RED_BASE + {2'd0, rsum};
        w_b_reg    <= BLUE_BASE - {2'd0, rsum};
    end

    // Stage two: weighted terms; the green weight is a shift.
    always_ff @(posedge clk)
    begin
        s2_idx_reg <= s1_idx_reg;
        term_r_reg <= {16'd0, w_r_reg} * {11'd0, sq_r_reg};
        term_g_reg <= {sq_g_reg, 11'd0};
        term_b_reg <= {16'd0, w_b_reg} * {11'd0, sq_b_reg};
    end

    // Stage three: sum of the three terms.
    always_ff @(posedge clk)
    begin
        s3_idx_reg <= s2_idx_reg;
        dist_reg   <= {2'd0, term_r_reg} + {2'd0, term_g_reg} + {2'd0, term_b_reg};
    end

    assign out_flags = s3_flags_reg;
    assign out_idx   = s3_idx_reg;
    assign out_dist  = dist_reg;
    assign busy      = s1_flags_reg.live | s2_flags_reg.live | s3_flags_reg.live;

endmodule
